// ===== rtl/mdu_pkg.sv =====
`default_nettype none

package mdu_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    localparam logic [DATA_W-1:0] SIGN32 = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ONES32 = {DATA_W{1'b1}};

    localparam logic [3:0] OP_MULT  = 4'd0;
    localparam logic [3:0] OP_MULTU = 4'd1;
    localparam logic [3:0] OP_MADD  = 4'd2;
    localparam logic [3:0] OP_MADDU = 4'd3;
    localparam logic [3:0] OP_MSUB  = 4'd4;
    localparam logic [3:0] OP_MSUBU = 4'd5;
    localparam logic [3:0] OP_MFHI  = 4'd6;
    localparam logic [3:0] OP_MTHI  = 4'd7;
    localparam logic [3:0] OP_MFLO  = 4'd8;
    localparam logic [3:0] OP_MTLO  = 4'd9;
    localparam logic [3:0] OP_DIV   = 4'd10;
    localparam logic [3:0] OP_DIVU  = 4'd11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_NEG,
        ST_ACC
    } state_t;

    // commands from the sequencer to the shift/add unit
    typedef struct packed {
        logic load;
        logic step;
        logic negate;
        logic is_div;
        logic is_signed;
    } dp_cmd_t;

    function automatic logic op_is_signed(input logic [3:0] op);
        return (op == OP_MULT) || (op == OP_MADD) || (op == OP_MSUB) || (op == OP_DIV);
    endfunction

    function automatic logic op_is_mul(input logic [3:0] op);
        return (op inside {[OP_MULT:OP_MSUBU]});
    endfunction

    function automatic logic op_is_div(input logic [3:0] op);
        return (op == OP_DIV) || (op == OP_DIVU);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mdu_req_if.sv =====
`default_nettype none

interface mdu_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    logic [31:0] rs_value;
    logic [31:0] rt_value;

    modport source (output valid, req_type, rs_value, rt_value, input ready);
    modport sink   (input valid, req_type, rs_value, rt_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/mdu_rsp_if.sv =====
`default_nettype none

interface mdu_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] hi_value;
    logic [31:0] lo_value;

    modport source (output valid, read_data, hi_value, lo_value, input ready);
    modport sink   (input valid, read_data, hi_value, lo_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/mdu_iter_unit.sv =====
`default_nettype none

module mdu_iter_unit
    import mdu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dp_cmd_t           cmd,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output      logic [PROD_W-1:0] result
);

    logic [PROD_W-1:0] p_reg, p_next;
    logic [DATA_W-1:0] m_reg, m_next;
    logic              div_reg, div_next;
    logic              neg_p_reg, neg_p_next;
    logic              neg_r_reg, neg_r_next;

    logic [DATA_W-1:0] ma, mb;
    logic [DATA_W:0]   alu_a, alu_b;
    logic [DATA_W+1:0] alu_res;
    logic [DATA_W-1:0] hi_fix, lo_fix;

    assign ma = (cmd.is_signed && a[DATA_W-1]) ? DATA_W'(0) - a : a;
    assign mb = (cmd.is_signed && b[DATA_W-1]) ? DATA_W'(0) - b : b;

    // one shared adder: add for shift-add multiply, subtract for restoring divide
    always_comb
    begin
        if (div_reg)
        begin
            alu_a   = p_reg[PROD_W-1:DATA_W-1];
            alu_b   = {1'b0, m_reg};
            alu_res = {1'b0, alu_a} + ~{1'b0, alu_b} + (DATA_W+2)'(1);
        end
        else
        begin
            alu_a   = {1'b0, p_reg[PROD_W-1:DATA_W]};
            alu_b   = p_reg[0] ? {1'b0, m_reg} : '0;
            alu_res = {1'b0, alu_a} + {1'b0, alu_b};
        end
    end

    assign hi_fix = neg_r_reg ? DATA_W'(0) - p_reg[PROD_W-1:DATA_W] : p_reg[PROD_W-1:DATA_W];
    assign lo_fix = neg_p_reg ? DATA_W'(0) - p_reg[DATA_W-1:0] : p_reg[DATA_W-1:0];

    always_comb
    begin
        p_next     = p_reg;
        m_next     = m_reg;
        div_next   = div_reg;
        neg_p_next = neg_p_reg;
        neg_r_next = neg_r_reg;
        if (cmd.load)
        begin
            div_next   = cmd.is_div;
            neg_p_next = cmd.is_signed && (a[DATA_W-1] ^ b[DATA_W-1]);
            neg_r_next = cmd.is_signed && a[DATA_W-1];
            if (cmd.is_div)
            begin
                m_next = mb;
                p_next = {{DATA_W{1'b0}}, ma};
            end
            else
            begin
                m_next = ma;
                p_next = {{DATA_W{1'b0}}, mb};
            end
        end
        else if (cmd.step)
        begin
            if (div_reg)
            begin
                // remainder fits again when the trial subtract does not borrow
                if (!alu_res[DATA_W+1])
                    p_next = {alu_res[DATA_W-1:0], p_reg[DATA_W-2:0], 1'b1};
                else
                    p_next = {p_reg[PROD_W-2:0], 1'b0};
            end
            else
            begin
                p_next = {alu_res[DATA_W:0], p_reg[DATA_W-1:1]};
            end
        end
        else if (cmd.negate)
        begin
            if (div_reg)
                p_next = {hi_fix, lo_fix};
            else if (neg_p_reg)
                p_next = PROD_W'(0) - p_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg   <= 1'b0;
            neg_p_reg <= 1'b0;
            neg_r_reg <= 1'b0;
        end
        else
        begin
            div_reg   <= div_next;
            neg_p_reg <= neg_p_next;
            neg_r_reg <= neg_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        m_reg <= m_next;
    end

    assign result = p_reg;

endmodule

`default_nettype wire

// ===== rtl/mdu_ctrl.sv =====
`default_nettype none

module mdu_ctrl
    import mdu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [3:0] in_op,
    input  wire logic       b_zero,
    input  wire logic       div_ovf,
    input  wire logic       out_free,
    output      logic       in_ready,
    output      logic       quick,
    output      logic       commit,
    output      logic [3:0] op_q,
    output      dp_cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       op_reg, op_next;
    logic             long_op;

    // divides by zero and the signed overflow case finish at once
    assign long_op = op_is_mul(in_op) ||
                     (op_is_div(in_op) && !b_zero && !(in_op == OP_DIV && div_ovf));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        in_ready      = 1'b0;
        quick         = 1'b0;
        commit        = 1'b0;
        cmd.load      = 1'b0;
        cmd.step      = 1'b0;
        cmd.negate    = 1'b0;
        cmd.is_div    = op_is_div(in_op);
        cmd.is_signed = op_is_signed(in_op);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (long_op)
                    begin
                        cmd.load   = 1'b1;
                        op_next    = in_op;
                        cnt_next   = '0;
                        state_next = ST_ITER;
                    end
                    else
                    begin
                        quick = 1'b1;
                    end
                end
            end
            ST_ITER:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = ST_NEG;
            end
            ST_NEG:
            begin
                cmd.negate = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            op_reg    <= OP_MULT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
        end
    end

    assign op_q = op_reg;

endmodule

`default_nettype wire

// ===== rtl/multiply_divide_unit.sv =====
// Multiply/divide unit with HI and LO registers.
// req (sink): req_type, rs_value, rt_value; a transfer happens when valid and
// ready are both high. rsp (source): read_data, hi_value, lo_value, one
// result per request, held until the receiver takes it.
// Moves, reads, unused codes, divide by zero and the signed 0x80000000 / -1
// case finish in the accept cycle: the result is valid the next cycle.
// Multiplies, multiply-accumulates and divides run through one shared 33-bit
// add/subtract unit, one bit per cycle: the iterate state steps through all 32
// bits, then a sign fix-up state and an accumulate/commit state follow, and
// the next request can be taken on the cycle the result is read.
// ready is low while an operation is in flight and while an unread result
// waits; a stalled receiver therefore holds off the next request, and a long
// operation waits in its commit cycle until the output register is free.
// Reset clears HI, LO, the sequencer and the output valid flag.
`default_nettype none

module multiply_divide_unit
    import mdu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mdu_req_if.sink   req,
    mdu_rsp_if.source rsp
);

    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              ovalid_reg, ovalid_next;

    logic              out_free, quick, commit, b_zero, div_ovf;
    logic [3:0]        op_q;
    dp_cmd_t           cmd;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] hilo, hilo_sum;

    assign out_free = !ovalid_reg || rsp.ready;
    assign b_zero   = (req.rt_value == '0);
    assign div_ovf  = (req.rs_value == SIGN32) && (req.rt_value == ONES32);

    mdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.req_type),
        .b_zero   (b_zero),
        .div_ovf  (div_ovf),
        .out_free (out_free),
        .in_ready (req.ready),
        .quick    (quick),
        .commit   (commit),
        .op_q     (op_q),
        .cmd      (cmd)
    );

    mdu_iter_unit u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .a      (req.rs_value),
        .b      (req.rt_value),
        .result (prod)
    );

    assign hilo     = {hi_reg, lo_reg};
    assign hilo_sum = (op_q == OP_MSUB || op_q == OP_MSUBU) ? hilo - prod : hilo + prod;

    always_comb
    begin
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        rd_next     = rd_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        if (quick)
        begin
            ovalid_next = 1'b1;
            rd_next     = '0;
            case (req.req_type)
                OP_MFHI: rd_next = hi_reg;
                OP_MTHI: hi_next = req.rs_value;
                OP_MFLO: rd_next = lo_reg;
                OP_MTLO: lo_next = req.rs_value;
                OP_DIV, OP_DIVU:
                begin
                    if (b_zero)
                    begin
                        hi_next = '0;
                        lo_next = '0;
                    end
                    else
                    begin
                        lo_next = SIGN32;
                    end
                end
                default: ;
            endcase
        end
        else if (commit)
        begin
            ovalid_next = 1'b1;
            rd_next     = '0;
            case (op_q)
                OP_MADD, OP_MADDU, OP_MSUB, OP_MSUBU:
                    {hi_next, lo_next} = hilo_sum;
                default:
                    {hi_next, lo_next} = prod;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg     <= '0;
            lo_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            hi_reg     <= hi_next;
            lo_reg     <= lo_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    // HI and LO only change when the output register is free
    assign rsp.valid     = ovalid_reg;
    assign rsp.read_data = rd_reg;
    assign rsp.hi_value  = hi_reg;
    assign rsp.lo_value  = lo_reg;

endmodule

`default_nettype wire
